// ===== hdl/cbcrc_pkg.sv =====
// Shared types and constants of the configurable bit-serial CRC block.
package cbcrc_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int POLY_W      = 32;
    localparam int WIDTH_W     = 6;
    localparam int INIT_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int NBITS_W     = 4;
    localparam int CRC_OUT_W   = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_POLY_LOW_TERMS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_WIDTH      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_VALUE  = 2'd2;

    localparam logic [POLY_W-1:0]  POLY_RESET  = 32'h0000_1021;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd16;
    localparam logic [INIT_W-1:0]  INIT_RESET  = 32'h0000_FFFF;

    localparam logic [NBITS_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic load;
        logic shift;
        logic emit;
    } cbcrc_cmd_t;

    typedef struct packed {
        logic bits_done;
        logic out_free;
    } cbcrc_status_t;

endpackage

// ===== hdl/cbcrc_datapath.sv =====
// Datapath of the CRC block: configuration registers, the CRC shift register and the result register.
module cbcrc_datapath
    import cbcrc_pkg::*;
#(
    parameter int MAX_CRC_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [BYTE_W-1:0]      s_data_byte,
    input  logic [NBITS_W-1:0]     s_bits_valid,
    input  logic                   s_start_of_message,
    input  cbcrc_cmd_t             cmd,
    output cbcrc_status_t          status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [CRC_OUT_W-1:0]   m_crc_value
);

    localparam int WIDX_W  = $clog2(MAX_CRC_WIDTH);
    localparam int WEXT_W  = WIDTH_W + 1;
    localparam logic [WEXT_W-1:0] MAX_W_EXT = WEXT_W'(MAX_CRC_WIDTH);

    logic [POLY_W-1:0]        poly_reg;
    logic [WIDTH_W-1:0]       width_reg;
    logic [INIT_W-1:0]        init_reg;
    logic [MAX_CRC_WIDTH-1:0] crc_reg, crc_next;
    logic [BYTE_W-1:0]        data_reg, data_next;
    logic [NBITS_W-1:0]       bits_left_reg, bits_left_next;
    logic                     m_valid_reg, m_valid_next;
    logic [CRC_OUT_W-1:0]     m_crc_value_reg;

    logic [WEXT_W-1:0]        width_ext;
    logic [WIDX_W-1:0]        top_index;
    logic [MAX_CRC_WIDTH-1:0] mask;
    logic [MAX_CRC_WIDTH-1:0] poly_masked;
    logic [MAX_CRC_WIDTH-1:0] crc_shifted;
    logic                     feedback;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg  <= POLY_RESET;
            width_reg <= WIDTH_RESET;
            init_reg  <= INIT_RESET;
        end else if (cfg_write_en) begin
            case (cfg_index)
                REG_POLY_LOW_TERMS: begin
                    poly_reg <= POLY_W'(cfg_data);
                end
                REG_CRC_WIDTH: begin
                    width_reg <= cfg_data[WIDTH_W-1:0];
                end
                REG_INITIAL_VALUE: begin
                    init_reg <= INIT_W'(cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    // The effective width is the register clamped to the range 1 to MAX_CRC_WIDTH.
    always_comb begin
        width_ext = {1'b0, width_reg};
        if (width_ext == '0) begin
            top_index = '0;
        end else if (width_ext > MAX_W_EXT) begin
            top_index = WIDX_W'(MAX_CRC_WIDTH - 1);
        end else begin
            top_index = WIDX_W'(width_ext - WEXT_W'(1));
        end
        for (int i = 0; i < MAX_CRC_WIDTH; i++) begin
            mask[i] = (WIDX_W'(i) <= top_index);
        end
    end

    assign poly_masked = MAX_CRC_WIDTH'(poly_reg) & mask;
    assign feedback    = data_reg[BYTE_W-1] ^ crc_reg[top_index];
    assign crc_shifted = {crc_reg[MAX_CRC_WIDTH-2:0], 1'b0} & mask;

    always_comb begin
        crc_next       = crc_reg;
        data_next      = data_reg;
        bits_left_next = bits_left_reg;
        if (cmd.load) begin
            if (s_start_of_message) begin
                crc_next = MAX_CRC_WIDTH'(init_reg) & mask;
            end else begin
                crc_next = crc_reg & mask;
            end
            data_next = s_data_byte;
            if (s_bits_valid > BITS_PER_BYTE) begin
                bits_left_next = BITS_PER_BYTE;
            end else begin
                bits_left_next = s_bits_valid;
            end
        end else if (cmd.shift) begin
            crc_next       = feedback ? (crc_shifted ^ poly_masked) : crc_shifted;
            data_next      = {data_reg[BYTE_W-2:0], 1'b0};
            bits_left_next = bits_left_reg - NBITS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= '0;
            bits_left_reg <= '0;
        end else begin
            crc_reg       <= crc_next;
            bits_left_reg <= bits_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_crc_value_reg <= CRC_OUT_W'(crc_reg);
        end
    end

    assign status.bits_done = (bits_left_reg == '0);
    assign status.out_free  = !m_valid_reg || m_ready;
    assign m_valid          = m_valid_reg;
    assign m_crc_value      = m_crc_value_reg;

endmodule

// ===== hdl/cbcrc_controller.sv =====
// Controller of the CRC block: sequences load, bit shifts and result hand-over.
module cbcrc_controller
    import cbcrc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cbcrc_status_t status,
    output cbcrc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SHIFT  = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (status.bits_done) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.shift = 1'b1;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/configurable_bitwise_crc.sv =====
// Top level of the configurable MSB-first bit-serial CRC block.
//
// Input items arrive on the s_ channel (valid/ready): a message byte, the
// number of its high-order bits to use (0 to 8, larger values act as 8) and
// a start-of-message flag that reloads the initial value first.
// Each item yields one result item on the m_ channel: the running CRC,
// masked to the configured width with the upper bits zero.
// The polynomial, width and initial value are set through the plain write
// port; the user must write them only while no item is in progress, and
// the block itself does not enforce this.
// An item is loaded, then shifted one used message bit at a time through
// the bit-serial shift register; the controller then finds the bit count
// spent and moves the CRC into the result register.
// The next item is taken as soon as the result has been registered, even if
// the receiver has not yet taken it; a stalled receiver holds the block in
// its final step until the result register is free.
// Reset restores the default CCITT-16 configuration and clears the CRC.
module configurable_bitwise_crc
    import cbcrc_pkg::*;
#(
    parameter int MAX_CRC_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [BYTE_W-1:0]      s_data_byte,
    input  logic [NBITS_W-1:0]     s_bits_valid,
    input  logic                   s_start_of_message,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [CRC_OUT_W-1:0]   m_crc_value
);

    cbcrc_cmd_t    cmd;
    cbcrc_status_t status;

    cbcrc_controller u_controller (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cbcrc_datapath #(
        .MAX_CRC_WIDTH (MAX_CRC_WIDTH)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_write_en       (cfg_write_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_data_byte        (s_data_byte),
        .s_bits_valid       (s_bits_valid),
        .s_start_of_message (s_start_of_message),
        .cmd                (cmd),
        .status             (status),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_crc_value        (m_crc_value)
    );

endmodule
